### design/chacha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared types, constants and the quarter-round function.
// ----------------------------------------------------------------------------
package chacha_pkg;

	localparam int DoubleRoundsDefault = 10;

	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	localparam logic [2:0] RegKeyA     = 3'd0;
	localparam logic [2:0] RegKeyB     = 3'd1;
	localparam logic [2:0] RegKeyC     = 3'd2;
	localparam logic [2:0] RegKeyD     = 3'd3;
	localparam logic [2:0] RegNonceLo  = 3'd4;
	localparam logic [2:0] RegNonceHi  = 3'd5;
	localparam logic [2:0] RegInitCtr  = 3'd6;

	typedef logic [15:0][31:0] cc_state_t;

	// request carried from the front to the back
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        first;
	} cc_req_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] ta, tb, tc, td;
		ta = a + b; td = rotl(d ^ ta, 16);
		tc = c + td; tb = rotl(b ^ tc, 12);
		ta = ta + tb; td = rotl(td ^ ta, 8);
		tc = tc + td; tb = rotl(tb ^ tc, 7);
		qround = {ta, tb, tc, td};
	endfunction

endpackage

### design/chacha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 front
// Two-entry request queue between the input channel and the back end.
// ----------------------------------------------------------------------------
module chacha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       data_word,
	input  logic [3:0]        valid_bytes,
	input  logic              first,
	output logic              req_valid,
	input  logic              req_ready,
	output chacha_pkg::cc_req_t req
);
	import chacha_pkg::*;

	cc_req_t    mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= '{data: data_word, count: valid_bytes, first: first};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### design/chacha_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 block core
// Iterative block function: one column or diagonal round per cycle,
// then the feed-forward add.
// ----------------------------------------------------------------------------
module chacha_core #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [255:0] key,
	input  logic [31:0] counter,
	input  logic [95:0] nonce,
	output logic        busy,
	output logic        done,
	output logic [511:0] block
);
	import chacha_pkg::*;

	localparam int Rounds = 2 * DOUBLE_ROUNDS;
	localparam int RW = $clog2(Rounds + 1);

	cc_state_t   init_q, w_q, nxt;
	logic [RW-1:0] rnd_q;
	logic        run_q, done_q;
	logic [127:0] q0, q1, q2, q3;

	always_comb begin
		nxt = w_q;
		if (!rnd_q[0]) begin
			q0 = qround(w_q[0], w_q[4], w_q[8], w_q[12]);
			q1 = qround(w_q[1], w_q[5], w_q[9], w_q[13]);
			q2 = qround(w_q[2], w_q[6], w_q[10], w_q[14]);
			q3 = qround(w_q[3], w_q[7], w_q[11], w_q[15]);
			{nxt[0], nxt[4], nxt[8], nxt[12]} = q0;
			{nxt[1], nxt[5], nxt[9], nxt[13]} = q1;
			{nxt[2], nxt[6], nxt[10], nxt[14]} = q2;
			{nxt[3], nxt[7], nxt[11], nxt[15]} = q3;
		end else begin
			q0 = qround(w_q[0], w_q[5], w_q[10], w_q[15]);
			q1 = qround(w_q[1], w_q[6], w_q[11], w_q[12]);
			q2 = qround(w_q[2], w_q[7], w_q[8], w_q[13]);
			q3 = qround(w_q[3], w_q[4], w_q[9], w_q[14]);
			{nxt[0], nxt[5], nxt[10], nxt[15]} = q0;
			{nxt[1], nxt[6], nxt[11], nxt[12]} = q1;
			{nxt[2], nxt[7], nxt[8], nxt[13]} = q2;
			{nxt[3], nxt[4], nxt[9], nxt[14]} = q3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			init_q <= {nonce, counter, key, Sigma3, Sigma2, Sigma1, Sigma0};
			w_q    <= {nonce, counter, key, Sigma3, Sigma2, Sigma1, Sigma0};
		end else if (run_q) begin
			w_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == RW'(Rounds - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	for (genvar i = 0; i < 16; i++) begin : g_ff
		assign block[32*i +: 32] = w_q[i] + init_q[i];
	end

	assign busy = run_q;
	assign done = done_q;

endmodule

### design/chacha_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Tracks counter and word position, runs the core, XORs and masks data.
// ----------------------------------------------------------------------------
module chacha_back #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  chacha_pkg::cc_req_t req,
	input  logic [255:0]      key,
	input  logic [95:0]       nonce,
	input  logic [31:0]       init_ctr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       result_word,
	output logic [3:0]        result_bytes
);
	import chacha_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_GEN  = 3'b010,
		ST_WAIT = 3'b100
	} st_t;

	st_t         st_q;
	logic [63:0] ks_q [8];
	logic [31:0] ctr_q;
	logic [2:0]  pos_q;
	logic        rdy_q;
	logic        fresh_q;
	logic        ov_q;
	logic [63:0] rw_q;
	logic [3:0]  rb_q;
	logic        start, done, busy;
	logic [511:0] blk;
	logic [31:0] gen_ctr;
	logic        need_gen;
	logic        fire;
	logic [63:0] mask;

	assign gen_ctr  = req.first ? init_ctr : ctr_q;
	// a first request needs a new block unless one was just made for it
	assign need_gen = (req.first && !fresh_q) || !rdy_q;
	// take a request only when the output stage is free or draining
	assign fire     = (st_q == ST_IDLE) && req_valid && !need_gen && (!ov_q || out_ready);
	assign start    = (st_q == ST_IDLE) && req_valid && need_gen;
	assign req_ready = fire;

	chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
		.clk, .arst_n, .start, .key, .counter(gen_ctr), .nonce,
		.busy, .done, .block(blk)
	);

	always_comb begin
		mask = '1;
		if (req.count < 4'd8) mask = (64'd1 << {req.count[2:0], 3'b000}) - 64'd1;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			for (int i = 0; i < 8; i++) ks_q[i] <= blk[64*i +: 64];
		end
		if (fire) begin
			rw_q <= (req.data ^ ks_q[pos_q]) & mask;
			rb_q <= req.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			ctr_q   <= '0;
			pos_q   <= '0;
			rdy_q   <= 1'b0;
			fresh_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (fire) begin
				ov_q    <= 1'b1;
				fresh_q <= 1'b0;
				pos_q   <= pos_q + 3'd1;
				if (pos_q == 3'd7) rdy_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						ctr_q <= gen_ctr + 32'd1;
						pos_q <= '0;
						st_q  <= ST_GEN;
					end
				end
				ST_GEN: begin
					if (done) begin
						rdy_q   <= 1'b1;
						fresh_q <= 1'b1;
						st_q    <= ST_WAIT;
					end
				end
				// pause in ST_WAIT, then return to idle and serve the held request from the new block
				ST_WAIT: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = ov_q;
	assign result_word  = rw_q;
	assign result_bytes = rb_q;

endmodule

### design/chacha20_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// XORs a little-endian byte stream with ChaCha20 keystream, up to eight bytes
// per request.
//
//   channel  | signals                               | handshake
//   ---------+---------------------------------------+-----------
//   in       | data_word, valid_bytes, first         | in_valid/in_ready
//   out      | result_word, result_bytes             | out_valid/out_ready
//   cfg      | cfg_we, cfg_index, cfg_data           | write only
//
// A request that finds keystream on hand is served straight from the held block;
// the request after every eighth (or any first request) waits
// for the iterative core, one round per cycle.
// The two-entry queue keeps taking input while the core runs, until both entries are full.
// Reset clears control; no clearing pass.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_word,
	output logic [3:0]  result_bytes,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import chacha_pkg::*;

	logic [63:0] ka_q, kb_q, kc_q, kd_q, nl_q;
	logic [31:0] nh_q, ic_q;
	logic        req_valid, req_ready;
	cc_req_t     req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ka_q <= '0; kb_q <= '0; kc_q <= '0; kd_q <= '0;
			nl_q <= '0; nh_q <= '0; ic_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKeyA:    ka_q <= cfg_data;
				RegKeyB:    kb_q <= cfg_data;
				RegKeyC:    kc_q <= cfg_data;
				RegKeyD:    kd_q <= cfg_data;
				RegNonceLo: nl_q <= cfg_data;
				RegNonceHi: nh_q <= cfg_data[31:0];
				RegInitCtr: ic_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	chacha_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_word, .valid_bytes, .first,
		.req_valid, .req_ready, .req
	);

	chacha_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
		.clk, .arst_n, .req_valid, .req_ready, .req,
		.key({kd_q, kc_q, kb_q, ka_q}), .nonce({nh_q, nl_q}), .init_ctr(ic_q),
		.out_valid, .out_ready, .result_word, .result_bytes
	);

endmodule

### design/chacha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
module chacha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_word,
	input logic [3:0]  result_bytes
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_word))
		else $error("result dropped while stalled");
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_bytes == 4'd0 |-> result_word == 64'd0)
		else $error("empty result not zero");
	a_mask1: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_bytes == 4'd1 |-> result_word[63:8] == 56'd0)
		else $error("bytes beyond count not zero");
endmodule

bind chacha20_stream_cipher chacha_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .result_word, .result_bytes
);
